// ===== src/urd_pkg.sv =====
// Shared types and constants for the unsigned restoring divider.
// No dependencies; used by every module of the block.
package urd_pkg;

  // Datapath width of the divider (4..64). Port fields stay 32 bits.
  localparam int unsigned WIDTH   = 32;
  localparam int unsigned FIELD_W = 32;

  // One pipeline slot, handed from cell to cell.
  typedef struct packed {
    logic             valid;
    logic [WIDTH-1:0] quo;
    logic [WIDTH-1:0] rem;
    logic [WIDTH-1:0] dsr;
  } urd_stage_t;

  // Finished result as seen on the port.
  typedef struct packed {
    logic [FIELD_W-1:0] quotient;
    logic [FIELD_W-1:0] remainder;
  } urd_result_t;

endpackage

// ===== src/unsigned_restoring_divider_top.sv =====
// Channel | handshake           | payload
// op      | op_valid / op_stall | dividend, divisor
// res     | res_valid/ res_stall| quotient, remainder
//
// One transaction accepted per cycle while op_stall is low; each passes
// through the chain of WIDTH division cells and then the output register.
// Reset clears valid flags only. A stalled result parks
// the next one in a skid slot; op_stall is raised only while that slot is full.
module unsigned_restoring_divider_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        op_valid,
  output logic                        op_stall,
  input  logic [urd_pkg::FIELD_W-1:0] dividend,
  input  logic [urd_pkg::FIELD_W-1:0] divisor,
  output logic                        res_valid,
  input  logic                        res_stall,
  output logic [urd_pkg::FIELD_W-1:0] quotient,
  output logic [urd_pkg::FIELD_W-1:0] remainder
);

  urd_pkg::urd_stage_t  chain [urd_pkg::WIDTH+1];
  urd_pkg::urd_result_t last_res;
  urd_pkg::urd_result_t res_data;
  urd_pkg::urd_stage_t  last;
  logic                 advance;
  logic                 zero_dsr;

  assign op_stall = ~advance;

  always_comb begin
    chain[0].valid = op_valid & advance;
    chain[0].quo   = urd_pkg::WIDTH'(dividend);
    chain[0].rem   = '0;
    chain[0].dsr   = urd_pkg::WIDTH'(divisor);
  end

  for (genvar i = 0; i < urd_pkg::WIDTH; i++) begin : g_cell
    urd_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .slot_in  (chain[i]),
      .slot_out (chain[i+1])
    );
  end

  // division by zero yields zero for both fields
  always_comb begin
    last               = chain[urd_pkg::WIDTH];
    zero_dsr           = (last.dsr == '0);
    last_res.quotient  = zero_dsr ? '0 : urd_pkg::FIELD_W'(last.quo);
    last_res.remainder = zero_dsr ? '0 : urd_pkg::FIELD_W'(last.rem);
  end

  urd_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .pipe_valid (last.valid),
    .pipe_data  (last_res),
    .advance    (advance),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_data   (res_data)
  );

  assign quotient  = res_data.quotient;
  assign remainder = res_data.remainder;

endmodule

// ===== src/urd_cell.sv =====
// One restoring-division cell: shift, trial subtract, restore or set bit.
// Registers its slot each advancing cycle. Depends on urd_pkg.
module urd_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  urd_pkg::urd_stage_t slot_in,
  output urd_pkg::urd_stage_t slot_out
);

  logic [urd_pkg::WIDTH:0]   shifted;
  logic [urd_pkg::WIDTH:0]   diff;
  logic                      fits;
  urd_pkg::urd_stage_t       slot_next;
  urd_pkg::urd_stage_t       slot;

  always_comb begin
    shifted = {slot_in.rem, slot_in.quo[urd_pkg::WIDTH-1]};
    diff    = shifted - {1'b0, slot_in.dsr};
    // no borrow out of the top bit: divisor fits
    fits    = ~diff[urd_pkg::WIDTH];

    slot_next       = slot_in;
    slot_next.quo   = {slot_in.quo[urd_pkg::WIDTH-2:0], fits};
    slot_next.rem   = fits ? diff[urd_pkg::WIDTH-1:0] : shifted[urd_pkg::WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid <= 1'b0;
    end else if (advance) begin
      slot <= slot_next;
    end
  end

  assign slot_out = slot;

endmodule

// ===== src/urd_out_buf.sv =====
// Output register with a skid slot between the cell chain and the result port.
// Depends on urd_pkg.
module urd_out_buf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pipe_valid,
  input  urd_pkg::urd_result_t pipe_data,
  output logic                 advance,
  output logic                 res_valid,
  input  logic                 res_stall,
  output urd_pkg::urd_result_t res_data
);

  logic                 out_valid;
  urd_pkg::urd_result_t out_data;
  logic                 skid_valid;
  urd_pkg::urd_result_t skid_data;
  logic                 out_free;

  // chain only moves while the skid slot is empty
  assign advance  = ~skid_valid;
  assign out_free = ~out_valid | ~res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= pipe_valid;
        out_data  <= pipe_data;
      end
    end else if (advance && pipe_valid) begin
      skid_valid <= 1'b1;
      skid_data  <= pipe_data;
    end
  end

  assign res_valid = out_valid;
  assign res_data  = out_data;

endmodule

// ===== src/urd_checker.sv =====
// Port-level checks for the divider, bound to the top level.
// Depends on urd_pkg for field widths.
module urd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        op_stall,
  input logic                        res_valid,
  input logic                        res_stall,
  input logic [urd_pkg::FIELD_W-1:0] quotient,
  input logic [urd_pkg::FIELD_W-1:0] remainder
);

  // reset empties the output register and the skid slot
  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!res_valid && !op_stall))
    else $error("result or stall left over after reset");

  // a full skid slot implies a result is waiting on the port
  a_stall_has_result: assert property (@(posedge clk) disable iff (rst)
    op_stall |-> res_valid)
    else $error("op_stall raised with no pending result");

  // skid slot is only ever occupied after a held result transaction
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(op_stall) |-> $past(res_valid && res_stall))
    else $error("op_stall raised without a stalled result");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(quotient) && $stable(remainder)))
    else $error("stalled result changed");

endmodule

bind unsigned_restoring_divider_top urd_checker u_urd_checker (
  .clk       (clk),
  .rst       (rst),
  .op_stall  (op_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .quotient  (quotient),
  .remainder (remainder)
);

// ===== tb/unsigned_restoring_divider_top_test.sv =====
// Self-checking testbench for unsigned_restoring_divider_top: a bit-level
// restoring division predictor feeds a scoreboard of expected results.
// Depends on urd_pkg and the divider RTL only.
`timescale 1ns / 100ps

class division_checker;
  urd_pkg::urd_result_t expected_results[$];
  int unsigned          mismatches = 0;

  // Shift, trial subtract, restore or set bit; WIDTH steps on a WIDTH+1 bit remainder.
  function automatic urd_pkg::urd_result_t restoring_divide(logic [31:0] num, logic [31:0] den);
    urd_pkg::urd_result_t         res;
    logic [63:0]                  wide;
    logic [urd_pkg::WIDTH-1:0]    quo;
    logic [urd_pkg::WIDTH-1:0]    dsr;
    logic [urd_pkg::WIDTH:0]      part;
    wide = {32'd0, num};
    quo  = wide[urd_pkg::WIDTH-1:0];
    wide = {32'd0, den};
    dsr  = wide[urd_pkg::WIDTH-1:0];
    part = '0;
    res  = '0;
    if (dsr == '0) begin
      return res;
    end
    for (int n = 0; n < urd_pkg::WIDTH; n++) begin
      part = {part[urd_pkg::WIDTH-1:0], quo[urd_pkg::WIDTH-1]};
      quo  = quo << 1;
      if (part >= {1'b0, dsr}) begin
        part   = part - {1'b0, dsr};
        quo[0] = 1'b1;
      end
    end
    wide = '0;
    wide[urd_pkg::WIDTH-1:0] = quo;
    res.quotient = wide[31:0];
    wide = '0;
    wide[urd_pkg::WIDTH-1:0] = part[urd_pkg::WIDTH-1:0];
    res.remainder = wide[31:0];
    return res;
  endfunction

  function void note_operands(logic [31:0] num, logic [31:0] den);
    expected_results.push_back(restoring_divide(num, den));
  endfunction

  function void check_result(logic [31:0] quo, logic [31:0] rem);
    urd_pkg::urd_result_t want;
    if (expected_results.size() == 0) begin
      $error("unexpected result: quotient %h remainder %h", quo, rem);
      mismatches++;
      return;
    end
    want = expected_results.pop_front();
    if (quo !== want.quotient) begin
      $error("quotient: expected %h, got %h", want.quotient, quo);
      mismatches++;
    end
    if (rem !== want.remainder) begin
      $error("remainder: expected %h, got %h", want.remainder, rem);
      mismatches++;
    end
  endfunction

  function int pending();
    return expected_results.size();
  endfunction
endclass

module unsigned_restoring_divider_top_test;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        op_valid  = 1'b0;
  logic        op_stall;
  logic [31:0] dividend  = '0;
  logic [31:0] divisor   = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic [31:0] quotient;
  logic [31:0] remainder;

  int unsigned tx_gap_max   = 12;
  int unsigned rx_gap_max   = 12;
  int unsigned rx_long_hold = 0;

  division_checker book = new();

  unsigned_restoring_divider_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid),
    .op_stall  (op_stall),
    .dividend  (dividend),
    .divisor   (divisor),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .quotient  (quotient),
    .remainder (remainder)
  );

  always #5 clk = ~clk;

  // Sampled before this edge's updates land, so both sides see pre-edge values.
  always @(posedge clk) begin
    if (!rst) begin
      if (op_valid && !op_stall) begin
        book.note_operands(dividend, divisor);
      end
      if (res_valid && !res_stall) begin
        book.check_result(quotient, remainder);
      end
    end
  end

  task automatic send_operands(input logic [31:0] num, input logic [31:0] den);
    int unsigned gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      op_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    op_valid <= 1'b1;
    dividend <= num;
    divisor  <= den;
    do @(posedge clk); while (op_stall);
  endtask

  task automatic drain_results();
    op_valid <= 1'b0;
    do @(posedge clk); while (book.pending() != 0);
  endtask

  function automatic void pick_operands(output logic [31:0] num, output logic [31:0] den);
    logic [31:0] k;
    num = $urandom;
    den = $urandom;
    case ($urandom_range(0, 7))
      0: den = '0;
      1: den = $urandom_range(1, 255);
      2: den[31] = 1'b1;
      3: den = 32'd1 << $urandom_range(0, 31);
      4: begin
        den = $urandom_range(1, 65535);
        k   = $urandom_range(0, 65535);
        num = den * k + $urandom_range(0, den - 1);
      end
      5: begin
        if (den == '0) den = 32'd1;
        num = $urandom % den;
      end
      default: ;
    endcase
  endfunction

  task automatic send_random(input int unsigned count);
    logic [31:0] num;
    logic [31:0] den;
    repeat (count) begin
      pick_operands(num, den);
      send_operands(num, den);
    end
  endtask

  // Result side: per transaction a random hold-off, or one long hold when asked.
  initial begin
    int unsigned hold;
    while (rst) @(posedge clk);
    forever begin
      if (rx_long_hold != 0) begin
        hold = rx_long_hold;
        rx_long_hold = 0;
      end else begin
        hold = $urandom_range(0, rx_gap_max);
      end
      if (hold > 0) begin
        res_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      res_stall <= 1'b0;
      do @(posedge clk); while (!res_valid);
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // edge operands, zero divisor, divisors with the top bit set
    send_operands(32'h0000_0000, 32'h0000_0000);
    send_operands(32'hFFFF_FFFF, 32'h0000_0000);
    send_operands(32'h0000_0000, 32'h0000_0001);
    send_operands(32'hFFFF_FFFF, 32'h0000_0001);
    send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_operands(32'h0000_0000, 32'hFFFF_FFFF);
    send_operands(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_operands(32'hFFFF_FFFF, 32'h8000_0000);
    send_operands(32'h7FFF_FFFF, 32'h8000_0000);
    send_operands(32'h8000_0000, 32'h8000_0000);
    send_operands(32'hC000_0001, 32'h8000_0001);
    send_operands(32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_operands(32'h8000_0000, 32'h0000_0002);
    send_operands(32'h0000_0001, 32'h0000_0002);
    send_operands(32'h0000_0064, 32'h0000_0007);
    send_operands(32'h0000_0005, 32'h0000_0005);
    send_operands(32'h1234_5678, 32'h0000_1000);
    send_operands(32'hAAAA_AAAA, 32'h5555_5555);
    send_operands(32'h5555_5555, 32'hAAAA_AAAA);
    send_operands(32'hDEAD_BEEF, 32'h0001_0000);
    send_operands(32'h0000_FFFF, 32'hFFFF_0000);

    send_random(500);

    // no idling on either side
    tx_gap_max = 0;
    rx_gap_max = 0;
    send_random(300);

    // long receiver hold-off while the sender keeps offering
    rx_gap_max   = 12;
    rx_long_hold = 200;
    send_random(200);

    drain_results();

    rx_gap_max = 0;
    tx_gap_max = 12;
    send_random(300);

    tx_gap_max = 0;
    rx_gap_max = 12;
    send_random(300);

    tx_gap_max = 12;
    send_random(200);

    drain_results();
    repeat (urd_pkg::WIDTH + 8) @(posedge clk);
    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
